// ===== sv/clt_pkg.sv =====
// Package for the combination lock with tamper guard.
// Shared types, register indexes, reset values, state and event codes.
// No dependencies.
package clt_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 10;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_WORD      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_LIMIT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_LIMIT_WT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KNOB_TARGET    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KNOB_MARGIN    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTEMPT_LIMIT  = 3'd5;

    // register reset values
    localparam logic [2:0] RST_CODE_WORD      = 3'd2;
    localparam logic [9:0] RST_LIGHT_LIMIT    = 10'd700;
    localparam logic [9:0] RST_LIGHT_LIMIT_WT = 10'd800;
    localparam logic [9:0] RST_KNOB_TARGET    = 10'd700;
    localparam logic [9:0] RST_KNOB_MARGIN    = 10'd100;
    localparam logic [3:0] RST_ATTEMPT_LIMIT  = 4'd3;

    localparam logic [1:0] DIGITS_FULL  = 2'd3;
    localparam logic [3:0] ATTEMPTS_MAX = 4'd15;

    // external lock_mode encoding
    localparam logic [1:0] LOCK_MODE_ENTER = 2'd0;
    localparam logic [1:0] LOCK_MODE_KNOB  = 2'd1;
    localparam logic [1:0] LOCK_MODE_OPEN  = 2'd2;
    localparam logic [1:0] LOCK_MODE_BLOCK = 2'd3;

    // event codes
    localparam logic [3:0] EV_NONE      = 4'd0;
    localparam logic [3:0] EV_DIGIT     = 4'd1;
    localparam logic [3:0] EV_WRONG     = 4'd2;
    localparam logic [3:0] EV_RIGHT     = 4'd3;
    localparam logic [3:0] EV_TAMPER    = 4'd4;
    localparam logic [3:0] EV_OPENED    = 4'd5;
    localparam logic [3:0] EV_CLOSED    = 4'd6;
    localparam logic [3:0] EV_UNBLOCKED = 4'd7;
    localparam logic [3:0] EV_ATT_BLOCK = 4'd8;

    typedef enum logic [3:0] {
        ST_ENTER = 4'b0001,
        ST_KNOB  = 4'b0010,
        ST_OPEN  = 4'b0100,
        ST_BLOCK = 4'b1000
    } mode_t;

    typedef struct packed {
        logic [2:0] code_word;
        logic [9:0] light_limit;
        logic [9:0] light_limit_waiting;
        logic [9:0] knob_target;
        logic [9:0] knob_margin;
        logic [3:0] attempt_limit;
    } cfg_t;

    typedef struct packed {
        mode_t      mode;
        logic       bolt;
        logic [2:0] digits;
        logic [1:0] count;
        logic [3:0] attempts;
    } lock_state_t;

    typedef struct packed {
        logic [9:0] light_level;
        logic [9:0] knob_level;
        logic       press_one;
        logic       press_two;
        logic       press_three;
        logic       hold_three;
    } poll_t;

    typedef struct packed {
        logic [1:0] lock_mode;
        logic       bolt_open;
        logic       lamp_on;
        logic [1:0] digits_entered;
        logic [3:0] attempts_used;
        logic [3:0] event_code;
    } result_t;

endpackage

// ===== sv/clt_ifs.sv =====
// Handshake channel interfaces for the combination lock.
// Depends on clt_pkg for the configuration port widths.
interface clt_poll_if;
    logic       valid;
    logic       ready;
    logic [9:0] light_level;
    logic [9:0] knob_level;
    logic       press_one;
    logic       press_two;
    logic       press_three;
    logic       hold_three;

    modport source (output valid, light_level, knob_level, press_one, press_two,
                    press_three, hold_three, input ready);
    modport sink   (input valid, light_level, knob_level, press_one, press_two,
                    press_three, hold_three, output ready);
endinterface

interface clt_status_if;
    logic       valid;
    logic       ready;
    logic [1:0] lock_mode;
    logic       bolt_open;
    logic       lamp_on;
    logic [1:0] digits_entered;
    logic [3:0] attempts_used;
    logic [3:0] event_code;

    modport source (output valid, lock_mode, bolt_open, lamp_on, digits_entered,
                    attempts_used, event_code, input ready);
    modport sink   (input valid, lock_mode, bolt_open, lamp_on, digits_entered,
                    attempts_used, event_code, output ready);
endinterface

interface clt_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [clt_pkg::CFG_IDX_W-1:0]  index;
    logic [clt_pkg::CFG_DATA_W-1:0] wdata;

    modport source (output valid, index, wdata, input ready);
    modport sink   (input valid, index, wdata, output ready);
endinterface

// ===== sv/clt_cfg_regs.sv =====
// Configuration register file of the combination lock.
// Depends on clt_pkg and clt_cfg_if.
module clt_cfg_regs (
    input  logic          clk,
    input  logic          rst_n,
    clt_cfg_if.sink       cfg,
    output clt_pkg::cfg_t regs
);

    clt_pkg::cfg_t cfg_reg;

    assign cfg.ready = 1'b1;
    assign regs      = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.code_word           <= clt_pkg::RST_CODE_WORD;
            cfg_reg.light_limit         <= clt_pkg::RST_LIGHT_LIMIT;
            cfg_reg.light_limit_waiting <= clt_pkg::RST_LIGHT_LIMIT_WT;
            cfg_reg.knob_target         <= clt_pkg::RST_KNOB_TARGET;
            cfg_reg.knob_margin         <= clt_pkg::RST_KNOB_MARGIN;
            cfg_reg.attempt_limit       <= clt_pkg::RST_ATTEMPT_LIMIT;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                clt_pkg::CFG_CODE_WORD:      cfg_reg.code_word           <= cfg.wdata[2:0];
                clt_pkg::CFG_LIGHT_LIMIT:    cfg_reg.light_limit         <= cfg.wdata;
                clt_pkg::CFG_LIGHT_LIMIT_WT: cfg_reg.light_limit_waiting <= cfg.wdata;
                clt_pkg::CFG_KNOB_TARGET:    cfg_reg.knob_target         <= cfg.wdata;
                clt_pkg::CFG_KNOB_MARGIN:    cfg_reg.knob_margin         <= cfg.wdata;
                clt_pkg::CFG_ATTEMPT_LIMIT:  cfg_reg.attempt_limit       <= cfg.wdata[3:0];
                default: ;
            endcase
        end
    end

endmodule

// ===== sv/clt_step.sv =====
// Next-state and result logic for one polling pass of the lock.
// Purely combinational. Depends on clt_pkg.
module clt_step (
    input  clt_pkg::cfg_t        cfg,
    input  clt_pkg::lock_state_t cur,
    input  clt_pkg::poll_t       poll,
    output clt_pkg::lock_state_t nxt,
    output clt_pkg::result_t     res
);

    logic       tamper;
    logic       tamper_wait;
    logic       knob_hit;
    logic       take_one;
    logic       take_two;
    logic [1:0] cnt_mid;
    logic [1:0] cnt_fin;
    logic [2:0] dig_fin;
    logic [3:0] att_inc;
    logic [3:0] ev;

    assign tamper      = (cur.mode != clt_pkg::ST_BLOCK) && (poll.light_level < cfg.light_limit);
    assign tamper_wait = poll.light_level < cfg.light_limit_waiting;

    // window without wrap: knob + margin >= target and knob <= target + margin
    assign knob_hit = ({1'b0, poll.knob_level} + {1'b0, cfg.knob_margin} >= {1'b0, cfg.knob_target})
                   && ({1'b0, poll.knob_level} <= {1'b0, cfg.knob_target} + {1'b0, cfg.knob_margin});

    // button one first, then button two
    assign take_one = poll.press_one && (cur.count != clt_pkg::DIGITS_FULL);
    assign cnt_mid  = take_one ? cur.count + 2'd1 : cur.count;
    assign take_two = poll.press_two && (cnt_mid != clt_pkg::DIGITS_FULL);
    assign cnt_fin  = take_two ? cnt_mid + 2'd1 : cnt_mid;
    assign dig_fin  = take_two ? (cur.digits | (3'b001 << cnt_mid)) : cur.digits;

    assign att_inc = (cur.attempts == clt_pkg::ATTEMPTS_MAX) ? cur.attempts
                                                             : cur.attempts + 4'd1;

    always_comb
    begin
        nxt = cur;
        ev  = clt_pkg::EV_NONE;
        if (tamper)
        begin
            nxt.mode     = clt_pkg::ST_BLOCK;
            nxt.attempts = '0;
            nxt.digits   = '0;
            nxt.count    = '0;
            ev           = clt_pkg::EV_TAMPER;
        end
        else
        begin
            unique case (cur.mode)
                clt_pkg::ST_BLOCK:
                begin
                    if (poll.hold_three)
                    begin
                        nxt.mode     = clt_pkg::ST_ENTER;
                        nxt.attempts = '0;
                        nxt.bolt     = 1'b0;
                        nxt.digits   = '0;
                        nxt.count    = '0;
                        ev           = clt_pkg::EV_UNBLOCKED;
                    end
                end
                clt_pkg::ST_OPEN:
                begin
                    if (poll.press_three)
                    begin
                        nxt.mode   = clt_pkg::ST_ENTER;
                        nxt.bolt   = 1'b0;
                        nxt.digits = '0;
                        nxt.count  = '0;
                        ev         = clt_pkg::EV_CLOSED;
                    end
                end
                clt_pkg::ST_KNOB:
                begin
                    if (tamper_wait)
                    begin
                        nxt.mode   = clt_pkg::ST_BLOCK;
                        nxt.digits = '0;
                        nxt.count  = '0;
                        ev         = clt_pkg::EV_TAMPER;
                    end
                    else if (knob_hit)
                    begin
                        nxt.mode = clt_pkg::ST_OPEN;
                        nxt.bolt = 1'b1;
                        ev       = clt_pkg::EV_OPENED;
                    end
                end
                default:
                begin
                    nxt.digits = dig_fin;
                    nxt.count  = cnt_fin;
                    if (take_one || take_two)
                        ev = clt_pkg::EV_DIGIT;
                    if (poll.press_three && (cnt_fin == clt_pkg::DIGITS_FULL))
                    begin
                        if (dig_fin == cfg.code_word)
                        begin
                            nxt.attempts = '0;
                            nxt.mode     = clt_pkg::ST_KNOB;
                            nxt.digits   = '0;
                            nxt.count    = '0;
                            ev           = clt_pkg::EV_RIGHT;
                        end
                        else
                        begin
                            nxt.attempts = att_inc;
                            ev           = clt_pkg::EV_WRONG;
                            if (att_inc >= cfg.attempt_limit)
                            begin
                                // entry stays full until unblocked
                                nxt.mode = clt_pkg::ST_BLOCK;
                                ev       = clt_pkg::EV_ATT_BLOCK;
                            end
                            else
                            begin
                                nxt.digits = '0;
                                nxt.count  = '0;
                            end
                        end
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (nxt.mode)
            clt_pkg::ST_KNOB:  res.lock_mode = clt_pkg::LOCK_MODE_KNOB;
            clt_pkg::ST_OPEN:  res.lock_mode = clt_pkg::LOCK_MODE_OPEN;
            clt_pkg::ST_BLOCK: res.lock_mode = clt_pkg::LOCK_MODE_BLOCK;
            default:           res.lock_mode = clt_pkg::LOCK_MODE_ENTER;
        endcase
        res.bolt_open      = nxt.bolt;
        res.lamp_on        = nxt.mode != clt_pkg::ST_OPEN;
        res.digits_entered = nxt.count;
        res.attempts_used  = nxt.attempts;
        res.event_code     = ev;
    end

endmodule

// ===== sv/combination_lock_with_tamper_core.sv =====
// Top level of the combination lock with light-tamper guard.
// Depends on clt_pkg, clt_ifs, clt_cfg_regs and clt_step.
//
//   channel  dir  per transaction
//   -------  ---  ---------------------------------------------------------
//   poll     in   one polling pass: light and knob samples, button events
//   status   out  one result per pass: mode, bolt, lamp, counts, event
//   cfg      in   one register write: index and data, always ready
//
// Timing: a pass is captured in the input register, then the step logic
//   updates the lock state and loads the result register at the same edge.
//   One pass per cycle sustained while status is taken.
// Throughput is set by the single lock-state update per cycle in this module.
// Reset: lock state and valid flags clear, cfg registers reload, at once.
// Stalls: a full result register holds the input register; poll.ready drops
//   only when both stages are full and status is not taken.
module combination_lock_with_tamper_core (
    input  logic        clk,
    input  logic        rst_n,
    clt_poll_if.sink    poll,
    clt_status_if.source status,
    clt_cfg_if.sink     cfg
);

    clt_pkg::cfg_t        cfg_regs;
    clt_pkg::poll_t       poll_reg;
    logic                 poll_valid_reg;
    clt_pkg::lock_state_t state_reg;
    clt_pkg::lock_state_t state_next;
    clt_pkg::result_t     result_next;
    clt_pkg::result_t     result_reg;
    logic                 result_valid_reg;
    logic                 advance;

    clt_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (cfg_regs)
    );

    clt_step u_step (
        .cfg  (cfg_regs),
        .cur  (state_reg),
        .poll (poll_reg),
        .nxt  (state_next),
        .res  (result_next)
    );

    // pass moves to the result register whenever that slot is free or draining
    assign advance    = poll_valid_reg && (!result_valid_reg || status.ready);
    assign poll.ready = !poll_valid_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            poll_valid_reg <= 1'b0;
        else if (poll.ready)
            poll_valid_reg <= poll.valid;
    end

    always_ff @(posedge clk)
    begin
        if (poll.valid && poll.ready)
        begin
            poll_reg.light_level <= poll.light_level;
            poll_reg.knob_level  <= poll.knob_level;
            poll_reg.press_one   <= poll.press_one;
            poll_reg.press_two   <= poll.press_two;
            poll_reg.press_three <= poll.press_three;
            poll_reg.hold_three  <= poll.hold_three;
        end
    end

    // lock state, updated once per pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode     <= clt_pkg::ST_ENTER;
            state_reg.bolt     <= 1'b0;
            state_reg.digits   <= '0;
            state_reg.count    <= '0;
            state_reg.attempts <= '0;
        end
        else if (advance)
            state_reg <= state_next;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (advance)
            result_valid_reg <= 1'b1;
        else if (status.ready)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            result_reg <= result_next;
    end

    assign status.valid          = result_valid_reg;
    assign status.lock_mode      = result_reg.lock_mode;
    assign status.bolt_open      = result_reg.bolt_open;
    assign status.lamp_on        = result_reg.lamp_on;
    assign status.digits_entered = result_reg.digits_entered;
    assign status.attempts_used  = result_reg.attempts_used;
    assign status.event_code     = result_reg.event_code;

    // bolt can only be open in the open mode or after tamper while open
    a_bolt_mode: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.bolt |-> (state_reg.mode == clt_pkg::ST_OPEN
                         || state_reg.mode == clt_pkg::ST_BLOCK))
        else $error("bolt open outside open or blocked mode");

    // a correct code clears both the entry and the attempt count
    a_knob_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.mode == clt_pkg::ST_KNOB || state_reg.mode == clt_pkg::ST_OPEN)
        |-> (state_reg.count == '0 && state_reg.attempts == '0))
        else $error("entry or attempts left over past code check");

    // every pass that leaves the input register shows up as a result
    a_advance_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> result_valid_reg)
        else $error("pass advanced without a result");

    // an unaccepted result never gets overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && !status.ready) |-> !advance)
        else $error("result overwritten while stalled");

endmodule

// ===== sim/clt_lock_checker.sv =====
// Scoreboard for the combination lock core: watches poll, status and cfg.
// Keeps its own model of the lock state and registers, compares each status
// transaction with the oldest expectation. Depends on clt_pkg and clt_ifs.
module clt_lock_checker (
    input  logic        clk,
    input  logic        rst_n,
    clt_poll_if         poll,
    clt_status_if       status,
    clt_cfg_if          cfg,
    output int unsigned mismatches,
    output int unsigned awaited
);
    import clt_pkg::*;

    cfg_t        regs;
    logic [1:0]  mode;
    logic        bolt;
    logic [2:0]  digits;
    logic [1:0]  count;
    logic [3:0]  attempts;

    result_t     expected_status_q[$];
    int unsigned fail_total = 0;
    poll_t       seen_pass;
    result_t     want;

    assign mismatches = fail_total;

    function automatic void clear_entry();
        digits = 3'd0;
        count  = 2'd0;
    endfunction

    // one polling pass through the lock
    function automatic result_t lock_step(input poll_t p);
        result_t r;
        logic [3:0] ev;
        int knob;
        int target;
        int margin;
        ev     = EV_NONE;
        knob   = int'(p.knob_level);
        target = int'(regs.knob_target);
        margin = int'(regs.knob_margin);
        if (mode != LOCK_MODE_BLOCK && p.light_level < regs.light_limit)
        begin
            mode     = LOCK_MODE_BLOCK;
            attempts = 4'd0;
            clear_entry();
            ev       = EV_TAMPER;
        end
        else if (mode == LOCK_MODE_BLOCK)
        begin
            if (p.hold_three)
            begin
                mode     = LOCK_MODE_ENTER;
                attempts = 4'd0;
                bolt     = 1'b0;
                clear_entry();
                ev       = EV_UNBLOCKED;
            end
        end
        else if (mode == LOCK_MODE_OPEN)
        begin
            if (p.press_three)
            begin
                mode = LOCK_MODE_ENTER;
                bolt = 1'b0;
                clear_entry();
                ev   = EV_CLOSED;
            end
        end
        else if (mode == LOCK_MODE_KNOB)
        begin
            if (p.light_level < regs.light_limit_waiting)
            begin
                mode = LOCK_MODE_BLOCK;
                clear_entry();
                ev   = EV_TAMPER;
            end
            else if (knob + margin >= target && knob <= target + margin)
            begin
                mode = LOCK_MODE_OPEN;
                bolt = 1'b1;
                ev   = EV_OPENED;
            end
        end
        else
        begin
            // button one before button two, then confirm
            if (p.press_one && count != DIGITS_FULL)
            begin
                count = count + 2'd1;
                ev    = EV_DIGIT;
            end
            if (p.press_two && count != DIGITS_FULL)
            begin
                digits[count] = 1'b1;
                count         = count + 2'd1;
                ev            = EV_DIGIT;
            end
            if (p.press_three && count == DIGITS_FULL)
            begin
                if (digits == regs.code_word)
                begin
                    attempts = 4'd0;
                    mode     = LOCK_MODE_KNOB;
                    clear_entry();
                    ev       = EV_RIGHT;
                end
                else
                begin
                    if (attempts != ATTEMPTS_MAX)
                        attempts = attempts + 4'd1;
                    ev = EV_WRONG;
                    if (attempts >= regs.attempt_limit)
                    begin
                        mode = LOCK_MODE_BLOCK;
                        ev   = EV_ATT_BLOCK;
                    end
                    else
                        clear_entry();
                end
            end
        end
        r.lock_mode      = mode;
        r.bolt_open      = bolt;
        r.lamp_on        = (mode != LOCK_MODE_OPEN);
        r.digits_entered = count;
        r.attempts_used  = attempts;
        r.event_code     = ev;
        return r;
    endfunction

    function automatic void check_field(input string field, input int unsigned exp_val,
                                        input int unsigned got_val);
        if (exp_val != got_val)
        begin
            $error("status %s: expected %0d, got %0d", field, exp_val, got_val);
            fail_total++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs = '{code_word: RST_CODE_WORD, light_limit: RST_LIGHT_LIMIT,
                     light_limit_waiting: RST_LIGHT_LIMIT_WT,
                     knob_target: RST_KNOB_TARGET, knob_margin: RST_KNOB_MARGIN,
                     attempt_limit: RST_ATTEMPT_LIMIT};
            mode     = LOCK_MODE_ENTER;
            bolt     = 1'b0;
            attempts = 4'd0;
            clear_entry();
            expected_status_q.delete();
            awaited <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_CODE_WORD:      regs.code_word           = cfg.wdata[2:0];
                    CFG_LIGHT_LIMIT:    regs.light_limit         = cfg.wdata;
                    CFG_LIGHT_LIMIT_WT: regs.light_limit_waiting = cfg.wdata;
                    CFG_KNOB_TARGET:    regs.knob_target         = cfg.wdata;
                    CFG_KNOB_MARGIN:    regs.knob_margin         = cfg.wdata;
                    CFG_ATTEMPT_LIMIT:  regs.attempt_limit       = cfg.wdata[3:0];
                    default: ;
                endcase
            end
            if (poll.valid && poll.ready)
            begin
                seen_pass.light_level = poll.light_level;
                seen_pass.knob_level  = poll.knob_level;
                seen_pass.press_one   = poll.press_one;
                seen_pass.press_two   = poll.press_two;
                seen_pass.press_three = poll.press_three;
                seen_pass.hold_three  = poll.hold_three;
                expected_status_q.push_back(lock_step(seen_pass));
            end
            if (status.valid && status.ready)
            begin
                if (expected_status_q.size() == 0)
                begin
                    $error("status transaction with no pass outstanding");
                    fail_total++;
                end
                else
                begin
                    want = expected_status_q.pop_front();
                    check_field("lock_mode", 32'(want.lock_mode), 32'(status.lock_mode));
                    check_field("bolt_open", 32'(want.bolt_open), 32'(status.bolt_open));
                    check_field("lamp_on", 32'(want.lamp_on), 32'(status.lamp_on));
                    check_field("digits_entered", 32'(want.digits_entered),
                                32'(status.digits_entered));
                    check_field("attempts_used", 32'(want.attempts_used),
                                32'(status.attempts_used));
                    check_field("event_code", 32'(want.event_code), 32'(status.event_code));
                end
            end
            awaited <= expected_status_q.size();
        end
    end

endmodule

// ===== sim/tb_combination_lock_with_tamper_core.sv =====
// Testbench top for combination_lock_with_tamper_core: clock, reset, stimulus
// and verdict. Depends on clt_pkg, clt_ifs, the core and clt_lock_checker.
module tb_combination_lock_with_tamper_core;
    import clt_pkg::*;

    localparam int HOLD_CYCLES    = 60;   // long receiver hold-off for back-pressure
    localparam int WATCHDOG_LIMIT = 2000; // cycles without any transaction
    localparam int SETTLE_CYCLES  = 4;    // extra wait after the scoreboard empties

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #1 clk = ~clk;

    clt_poll_if   poll_ch ();
    clt_status_if status_ch ();
    clt_cfg_if    cfg_ch ();

    combination_lock_with_tamper_core u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .poll   (poll_ch),
        .status (status_ch),
        .cfg    (cfg_ch)
    );

    int unsigned fail_count;
    int unsigned pending_count;

    clt_lock_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .poll       (poll_ch),
        .status     (status_ch),
        .cfg        (cfg_ch),
        .mismatches (fail_count),
        .awaited    (pending_count)
    );

    // Pacing knobs, set per phase by the stimulus.
    int src_idle_pct  = 0;
    int snk_stall_pct = 0;
    bit hold_request  = 1'b0;

    // Register values as last written; used to aim stimulus (benign light,
    // knob window, the right code) and written back by the first phase.
    cfg_t shadow;
    int   sent = 0;

    //------------------------------------------------------------------
    // Status receiver. Stalls at random per phase; once per run it
    // holds ready low for HOLD_CYCLES so the core backs up into poll.
    //------------------------------------------------------------------
    logic sink_ready = 1'b0;
    int   hold_left  = 0;
    bit   hold_armed = 1'b0;

    assign status_ch.ready = sink_ready;

    always @(posedge clk)
    begin
        if (!rst_n)
            sink_ready <= 1'b0;
        else if (hold_left != 0)
        begin
            sink_ready <= 1'b0;
            hold_left  <= hold_left - 1;
        end
        else if (hold_request && !hold_armed)
        begin
            hold_armed <= 1'b1;
            hold_left  <= HOLD_CYCLES;
            sink_ready <= 1'b0;
        end
        else
            sink_ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    //------------------------------------------------------------------
    // Watchdog: any cycle with no transaction on any channel counts.
    //------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (!rst_n || (poll_ch.valid && poll_ch.ready) ||
            (status_ch.valid && status_ch.ready) || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb_combination_lock_with_tamper_core: done, errors");
                $finish;
            end
        end
    end

    //------------------------------------------------------------------
    // Pass construction
    //------------------------------------------------------------------
    function automatic poll_t mk(input int light, input int knob, input bit p1,
                                 input bit p2, input bit p3, input bit h3);
        poll_t p;
        p.light_level = 10'(light);
        p.knob_level  = 10'(knob);
        p.press_one   = p1;
        p.press_two   = p2;
        p.press_three = p3;
        p.hold_three  = h3;
        return p;
    endfunction

    // Light at or above both thresholds: no tamper in any mode.
    function automatic int calm_light();
        int floor_lvl;
        floor_lvl = (shadow.light_limit > shadow.light_limit_waiting) ?
                    int'(shadow.light_limit) : int'(shadow.light_limit_waiting);
        return $urandom_range(1023, floor_lvl);
    endfunction

    function automatic int window_knob();
        int lo;
        int hi;
        lo = int'(shadow.knob_target) - int'(shadow.knob_margin);
        hi = int'(shadow.knob_target) + int'(shadow.knob_margin);
        if (lo < 0)
            lo = 0;
        if (hi > 1023)
            hi = 1023;
        return $urandom_range(hi, lo);
    endfunction

    function automatic poll_t calm_pass(input bit p1, input bit p2, input bit p3,
                                        input bit h3);
        return mk(calm_light(), $urandom_range(1023), p1, p2, p3, h3);
    endfunction

    function automatic poll_t noise_pass();
        return mk($urandom_range(1023), $urandom_range(1023), 1'($urandom_range(1)),
                  1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)));
    endfunction

    //------------------------------------------------------------------
    // Channel drivers
    //------------------------------------------------------------------
    // Valid stays high from one transaction into the next unless an idle
    // cycle is drawn; it is only dropped in a step where nothing raises it.
    task automatic send_pass(input poll_t p);
        while ($urandom_range(99) < src_idle_pct)
        begin
            poll_ch.valid <= 1'b0;
            @(posedge clk);
        end
        poll_ch.valid       <= 1'b1;
        poll_ch.light_level <= p.light_level;
        poll_ch.knob_level  <= p.knob_level;
        poll_ch.press_one   <= p.press_one;
        poll_ch.press_two   <= p.press_two;
        poll_ch.press_three <= p.press_three;
        poll_ch.hold_three  <= p.hold_three;
        do
            @(posedge clk);
        while (!poll_ch.ready);
        sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.wdata <= val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
    endtask

    // Every pass yields exactly one status, so an empty scoreboard means
    // the core is idle; a few extra cycles cover its two-stage pipe.
    task automatic wait_lock_quiet();
        poll_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apply_config(input cfg_t c);
        write_reg(CFG_CODE_WORD, 10'(c.code_word));
        write_reg(CFG_LIGHT_LIMIT, c.light_limit);
        write_reg(CFG_LIGHT_LIMIT_WT, c.light_limit_waiting);
        write_reg(CFG_KNOB_TARGET, c.knob_target);
        write_reg(CFG_KNOB_MARGIN, c.knob_margin);
        write_reg(CFG_ATTEMPT_LIMIT, 10'(c.attempt_limit));
        cfg_ch.valid <= 1'b0;
        shadow = c;
        @(posedge clk);
    endtask

    //------------------------------------------------------------------
    // Directed opening under reset register values
    // (code 2: button one, button two, button one).
    //------------------------------------------------------------------
    task automatic directed_passes();
        send_pass(mk(0, 0, 0, 0, 0, 0));          // dark while entering: tamper
        send_pass(mk(1023, 1023, 1, 1, 1, 0));    // blocked ignores every click
        send_pass(mk(1023, 0, 0, 0, 0, 1));       // long hold unblocks
        send_pass(mk(900, 700, 0, 0, 1, 0));      // confirm with no digits: nothing
        send_pass(mk(900, 700, 1, 0, 0, 0));
        send_pass(mk(900, 700, 1, 1, 0, 0));      // both buttons, one then two
        send_pass(mk(900, 700, 0, 1, 0, 0));      // fourth digit dropped
        send_pass(mk(900, 700, 0, 0, 1, 0));      // wrong code, one attempt
        send_pass(mk(900, 700, 1, 0, 0, 0));
        send_pass(mk(900, 700, 1, 1, 1, 0));      // digits and confirm in one pass
        send_pass(mk(900, 700, 1, 0, 0, 0));
        send_pass(mk(900, 700, 1, 0, 0, 0));
        send_pass(mk(900, 700, 1, 0, 1, 0));      // third wrong code: attempt block
        send_pass(mk(0, 0, 0, 0, 0, 1));          // unblock even while dark
        send_pass(mk(900, 0, 1, 0, 0, 0));
        send_pass(mk(900, 0, 0, 1, 0, 0));
        send_pass(mk(900, 0, 1, 0, 1, 0));        // right code: awaiting knob
        send_pass(mk(750, 700, 0, 0, 0, 0));      // dim light while waiting: tamper
        send_pass(mk(1023, 0, 0, 0, 0, 1));
        send_pass(mk(1023, 0, 1, 0, 0, 0));
        send_pass(mk(1023, 0, 0, 1, 0, 0));
        send_pass(mk(1023, 0, 1, 0, 1, 0));
        send_pass(mk(800, 801, 0, 0, 0, 0));      // light on the threshold, knob past window
        send_pass(mk(1023, 800, 0, 0, 0, 0));     // upper window edge opens
        send_pass(mk(699, 0, 0, 0, 0, 0));        // tamper while open, bolt stays
        send_pass(mk(1023, 0, 0, 0, 0, 1));       // hold closes the bolt
    endtask

    //------------------------------------------------------------------
    // Random traffic: mostly whole unlock sessions, some noise.
    //------------------------------------------------------------------
    task automatic run_session();
        poll_t      p;
        logic [2:0] code;
        int         n_knob;
        int         roll;
        int         tamper_lo;
        code = ($urandom_range(99) < 65) ? shadow.code_word : 3'($urandom_range(7));
        // start clean: unblock if blocked, close if left open
        send_pass(calm_pass(1'b0, 1'b0, 1'b1, 1'b1));
        for (int i = 0; i < 3; i++)
        begin
            p = calm_pass(!code[i], code[i], 1'b0, 1'b0);
            if ($urandom_range(9) == 0)
                p.press_one = 1'b1;
            if (i == 2 && $urandom_range(9) == 0)
                p.press_three = 1'b1;
            send_pass(p);
        end
        send_pass(calm_pass(1'b0, 1'b0, 1'b1, 1'($urandom_range(1))));
        n_knob = $urandom_range(3, 1);
        for (int i = 0; i < n_knob; i++)
        begin
            p    = calm_pass(1'b0, 1'b0, 1'($urandom_range(1)), 1'b0);
            roll = $urandom_range(99);
            if (roll < 10 && shadow.light_limit < shadow.light_limit_waiting)
            begin
                tamper_lo     = int'(shadow.light_limit);
                p.light_level = 10'($urandom_range(int'(shadow.light_limit_waiting) - 1,
                                                   tamper_lo));
            end
            else if (roll < 70)
                p.knob_level = 10'(window_knob());
            send_pass(p);
        end
        roll = $urandom_range(99);
        if (roll < 80)
            send_pass(calm_pass(1'b0, 1'b0, 1'b1, 1'b0));
        else if (roll < 90 && shadow.light_limit != 0)
            send_pass(mk($urandom_range(int'(shadow.light_limit) - 1), 0, 0, 0, 0, 0));
        else
            send_pass(calm_pass(1'b0, 1'b0, 1'b0, 1'b0));
    endtask

    task automatic run_phase(input cfg_t c, input int src_pct, input int snk_pct,
                             input int n_items, input bit pressure);
        int goal;
        wait_lock_quiet();
        apply_config(c);
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        if (pressure)
            hold_request = 1'b1;
        goal = sent + n_items;
        while (sent < goal)
        begin
            if ($urandom_range(99) < 75)
                run_session();
            else
                repeat ($urandom_range(4, 1)) send_pass(noise_pass());
        end
    endtask

    function automatic cfg_t random_config();
        cfg_t c;
        c.code_word           = 3'($urandom_range(7));
        c.light_limit         = 10'($urandom_range(800));
        c.light_limit_waiting = 10'($urandom_range(1023));
        c.knob_target         = 10'($urandom_range(1023));
        c.knob_margin         = 10'($urandom_range(200));
        c.attempt_limit       = 4'($urandom_range(15, 1));
        return c;
    endfunction

    //------------------------------------------------------------------
    // Main sequence
    //------------------------------------------------------------------
    initial
    begin
        poll_ch.valid       = 1'b0;
        poll_ch.light_level = '0;
        poll_ch.knob_level  = '0;
        poll_ch.press_one   = 1'b0;
        poll_ch.press_two   = 1'b0;
        poll_ch.press_three = 1'b0;
        poll_ch.hold_three  = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = '0;
        cfg_ch.wdata        = '0;
        shadow = '{code_word: RST_CODE_WORD, light_limit: RST_LIGHT_LIMIT,
                   light_limit_waiting: RST_LIGHT_LIMIT_WT,
                   knob_target: RST_KNOB_TARGET, knob_margin: RST_KNOB_MARGIN,
                   attempt_limit: RST_ATTEMPT_LIMIT};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_passes();

        // reset values written back, no idling, one long receiver hold-off
        run_phase(shadow, 0, 0, 350, 1'b1);
        // extremes: no light tamper, widest waiting threshold, tight window
        // at zero, single attempt
        run_phase('{code_word: 3'd7, light_limit: 10'd0, light_limit_waiting: 10'd1023,
                    knob_target: 10'd0, knob_margin: 10'd0, attempt_limit: 4'd1},
                  84, 0, 250, 1'b0);
        // other extremes: tamper below full scale, window covers everything
        run_phase('{code_word: 3'd0, light_limit: 10'd1023, light_limit_waiting: 10'd0,
                    knob_target: 10'd1023, knob_margin: 10'd1023, attempt_limit: 4'd15},
                  0, 84, 250, 1'b0);
        // attempt limit of zero: any wrong code blocks at once
        run_phase('{code_word: 3'd5, light_limit: 10'd300, light_limit_waiting: 10'd600,
                    knob_target: 10'd512, knob_margin: 10'd37, attempt_limit: 4'd0},
                  9, 9, 300, 1'b0);
        run_phase(random_config(), 0, 0, 200, 1'b0);
        run_phase(random_config(), 84, 0, 200, 1'b0);
        run_phase(random_config(), 0, 84, 200, 1'b0);

        wait_lock_quiet();
        if (fail_count == 0)
            $display("tb_combination_lock_with_tamper_core: done, clean");
        else
            $display("tb_combination_lock_with_tamper_core: done, errors");
        $finish;
    end

endmodule
